>>> src/rv32i_instruction_decoder_macros.svh
// ---------------------------------------------------------------------------
// rv32i instruction decoder assertion macros
// shared property shapes for the decoder checks, clocked on clk,
// quiet while arst_n is low
// ---------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_DECODER_MACROS_SVH
`define RV32I_INSTRUCTION_DECODER_MACROS_SVH

// same-cycle implication
`define RV32ID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RV32ID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rv32id_pkg.sv
// ---------------------------------------------------------------------------
// rv32id_pkg
// opcodes, format classes, instruction numbers and the decoded result type
// ---------------------------------------------------------------------------
package rv32id_pkg;

	localparam int InstrWidth  = 32;
	localparam int ResultWidth = 64;

	// major opcodes
	localparam logic [6:0] OP_REG    = 7'd51;
	localparam logic [6:0] OP_IMM    = 7'd19;
	localparam logic [6:0] OP_LOAD   = 7'd3;
	localparam logic [6:0] OP_JALR   = 7'd103;
	localparam logic [6:0] OP_STORE  = 7'd35;
	localparam logic [6:0] OP_BRANCH = 7'd99;
	localparam logic [6:0] OP_LUI    = 7'd55;
	localparam logic [6:0] OP_JAL    = 7'd111;

	// funct7 values of register ops
	localparam logic [6:0] F7_BASE = 7'd0;
	localparam logic [6:0] F7_ALT  = 7'd32;

	// format classes
	localparam logic [2:0] FMT_UNKNOWN = 3'd0;
	localparam logic [2:0] FMT_R       = 3'd1;
	localparam logic [2:0] FMT_I       = 3'd2;
	localparam logic [2:0] FMT_S       = 3'd3;
	localparam logic [2:0] FMT_SB      = 3'd4;
	localparam logic [2:0] FMT_U       = 3'd5;
	localparam logic [2:0] FMT_UJ      = 3'd6;

	// instruction numbers
	localparam logic [5:0] ID_NONE  = 6'd0;
	localparam logic [5:0] ID_ADD   = 6'd1;
	localparam logic [5:0] ID_SUB   = 6'd2;
	localparam logic [5:0] ID_XOR   = 6'd3;
	localparam logic [5:0] ID_OR    = 6'd4;
	localparam logic [5:0] ID_AND   = 6'd5;
	localparam logic [5:0] ID_SLL   = 6'd6;
	localparam logic [5:0] ID_SRL   = 6'd7;
	localparam logic [5:0] ID_SRA   = 6'd8;
	localparam logic [5:0] ID_SLT   = 6'd9;
	localparam logic [5:0] ID_SLTU  = 6'd10;
	localparam logic [5:0] ID_ADDI  = 6'd11;
	localparam logic [5:0] ID_XORI  = 6'd12;
	localparam logic [5:0] ID_ORI   = 6'd13;
	localparam logic [5:0] ID_ANDI  = 6'd14;
	localparam logic [5:0] ID_SLTI  = 6'd15;
	localparam logic [5:0] ID_SLTIU = 6'd16;
	localparam logic [5:0] ID_LB    = 6'd17;
	localparam logic [5:0] ID_LH    = 6'd18;
	localparam logic [5:0] ID_LW    = 6'd19;
	localparam logic [5:0] ID_LBU   = 6'd20;
	localparam logic [5:0] ID_LHU   = 6'd21;
	localparam logic [5:0] ID_JALR  = 6'd22;
	localparam logic [5:0] ID_SB    = 6'd23;
	localparam logic [5:0] ID_SH    = 6'd24;
	localparam logic [5:0] ID_SW    = 6'd25;
	localparam logic [5:0] ID_BEQ   = 6'd26;
	localparam logic [5:0] ID_BNE   = 6'd27;
	localparam logic [5:0] ID_BLT   = 6'd28;
	localparam logic [5:0] ID_BGE   = 6'd29;
	localparam logic [5:0] ID_BLTU  = 6'd30;
	localparam logic [5:0] ID_BGEU  = 6'd31;
	localparam logic [5:0] ID_LUI   = 6'd32;
	localparam logic [5:0] ID_JAL   = 6'd33;

	// decoded instruction
	typedef struct packed {
		logic [6:0]         opcode;
		logic [2:0]         format_class;
		logic [5:0]         instr_id;
		logic [4:0]         dest_reg;
		logic [4:0]         src_reg_a;
		logic [4:0]         src_reg_b;
		logic [2:0]         funct_three;
		logic [6:0]         funct_seven;
		logic signed [19:0] immediate;
	} dec_result_t;

endpackage

>>> src/rv32id_decode.sv
// ---------------------------------------------------------------------------
// rv32id_decode
// combinational split of one instruction word into format, number and fields
// ---------------------------------------------------------------------------
module rv32id_decode
	import rv32id_pkg::*;
(
	input  logic [InstrWidth-1:0] instr,
	output dec_result_t           result
);

	logic [4:0] rd;
	logic [2:0] f3;
	logic [4:0] rs1;
	logic [4:0] rs2;
	logic [6:0] f7;

	assign rd  = instr[11:7];
	assign f3  = instr[14:12];
	assign rs1 = instr[19:15];
	assign rs2 = instr[24:20];
	assign f7  = instr[31:25];

	// field selection and instruction number per opcode
	always_comb begin
		result        = '0;
		result.opcode = instr[6:0];
		unique case (instr[6:0])
			OP_REG: begin
				result.format_class = FMT_R;
				result.dest_reg     = rd;
				result.src_reg_a    = rs1;
				result.src_reg_b    = rs2;
				result.funct_three  = f3;
				result.funct_seven  = f7;
				if (f7 == F7_BASE) begin
					unique case (f3)
						3'd0: result.instr_id = ID_ADD;
						3'd1: result.instr_id = ID_SLL;
						3'd2: result.instr_id = ID_SLT;
						3'd3: result.instr_id = ID_SLTU;
						3'd4: result.instr_id = ID_XOR;
						3'd5: result.instr_id = ID_SRL;
						3'd6: result.instr_id = ID_OR;
						default: result.instr_id = ID_AND;
					endcase
				end else if (f7 == F7_ALT && f3 == 3'd0) begin
					result.instr_id = ID_SUB;
				end else if (f7 == F7_ALT && f3 == 3'd5) begin
					result.instr_id = ID_SRA;
				end else begin
					result.instr_id = ID_NONE;
				end
			end
			OP_IMM, OP_LOAD, OP_JALR: begin
				result.format_class = FMT_I;
				result.dest_reg     = rd;
				result.src_reg_a    = rs1;
				result.funct_three  = f3;
				result.immediate    = {{8{instr[31]}}, instr[31:20]};
				if (instr[6:0] == OP_IMM) begin
					unique case (f3)
						3'd0: result.instr_id = ID_ADDI;
						3'd2: result.instr_id = ID_SLTI;
						3'd3: result.instr_id = ID_SLTIU;
						3'd4: result.instr_id = ID_XORI;
						3'd6: result.instr_id = ID_ORI;
						3'd7: result.instr_id = ID_ANDI;
						default: result.instr_id = ID_NONE;
					endcase
				end else if (instr[6:0] == OP_LOAD) begin
					unique case (f3)
						3'd0: result.instr_id = ID_LB;
						3'd1: result.instr_id = ID_LH;
						3'd2: result.instr_id = ID_LW;
						3'd4: result.instr_id = ID_LBU;
						3'd5: result.instr_id = ID_LHU;
						default: result.instr_id = ID_NONE;
					endcase
				end else begin
					// jalr ignores funct3
					result.instr_id = ID_JALR;
				end
			end
			OP_STORE: begin
				result.format_class = FMT_S;
				result.src_reg_a    = rs1;
				result.src_reg_b    = rs2;
				result.funct_three  = f3;
				result.immediate    = {{8{instr[31]}}, instr[31:25], instr[11:7]};
				unique case (f3)
					3'd0: result.instr_id = ID_SB;
					3'd1: result.instr_id = ID_SH;
					3'd2: result.instr_id = ID_SW;
					default: result.instr_id = ID_NONE;
				endcase
			end
			OP_BRANCH: begin
				result.format_class = FMT_SB;
				result.src_reg_a    = rs1;
				result.src_reg_b    = rs2;
				result.funct_three  = f3;
				// halved offset, low zero bit dropped
				result.immediate    = {{8{instr[31]}}, instr[31], instr[7],
					instr[30:25], instr[11:8]};
				unique case (f3)
					3'd0: result.instr_id = ID_BEQ;
					3'd1: result.instr_id = ID_BNE;
					3'd4: result.instr_id = ID_BLT;
					3'd5: result.instr_id = ID_BGE;
					3'd6: result.instr_id = ID_BLTU;
					3'd7: result.instr_id = ID_BGEU;
					default: result.instr_id = ID_NONE;
				endcase
			end
			OP_LUI: begin
				result.format_class = FMT_U;
				result.instr_id     = ID_LUI;
				result.dest_reg     = rd;
				result.immediate    = instr[31:12];
			end
			OP_JAL: begin
				result.format_class = FMT_UJ;
				result.instr_id     = ID_JAL;
				result.dest_reg     = rd;
				// halved jump offset
				result.immediate    = {instr[31], instr[19:12], instr[20], instr[30:21]};
			end
			default: begin
				result.format_class = FMT_UNKNOWN;
			end
		endcase
	end

endmodule

>>> src/rv32i_instruction_decoder.sv
// ---------------------------------------------------------------------------
// rv32i_instruction_decoder
// Decodes one RV32I instruction word per transaction into opcode, format
// class, instruction number, register fields, funct fields and a packed
// 20-bit sign-extended immediate (branch and jump offsets halved). One word
// is accepted every clock cycle when the output side keeps up. An accepted
// word is held in the input register, decoded by the combinational decode
// logic and captured in the result register, whose valid flag drives the
// output. Backpressure on the output stalls both stages. A new word is
// still taken while a finished result waits, as long as the input register
// is free.
// ---------------------------------------------------------------------------
`include "rv32i_instruction_decoder_macros.svh"

module rv32i_instruction_decoder
	import rv32id_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [InstrWidth-1:0]  s_axis_tdata,  // [31:0] instr_word
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [6:0] opcode, [9:7] format_class, [15:10] instr_id, [20:16] dest_reg,
	// [25:21] src_reg_a, [30:26] src_reg_b, [33:31] funct_three,
	// [40:34] funct_seven, [60:41] immediate, [63:61] zero
	output logic [ResultWidth-1:0] m_axis_tdata
);

	logic                  valid_s1;
	logic [InstrWidth-1:0] instr_s1;
	logic                  valid_s2;
	dec_result_t           res_s2;
	dec_result_t           dec_res;
	logic                  s2_ready;
	logic                  in_txn;

	// stage handshakes
	assign s2_ready      = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || s2_ready;
	assign in_txn        = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_txn) begin
			valid_s1 <= 1'b1;
		end else if (s2_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_txn) begin
			instr_s1 <= s_axis_tdata;
		end
	end

	rv32id_decode u_decode (
		.instr  (instr_s1),
		.result (dec_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			res_s2 <= dec_res;
		end
	end

	// output packing
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2.immediate, res_s2.funct_seven,
		res_s2.funct_three, res_s2.src_reg_b, res_s2.src_reg_a, res_s2.dest_reg,
		res_s2.instr_id, res_s2.format_class, res_s2.opcode};

	// checks
	`RV32ID_ASSERT_NEXT(a_in_lands_s1, in_txn, valid_s1, "accepted word missing from stage 1")
	`RV32ID_ASSERT_NEXT(a_s1_moves_s2, valid_s1 && s2_ready, valid_s2, "stage 1 item lost on its way out")
	`RV32ID_ASSERT_NOW(a_unknown_clear, valid_s2 && res_s2.format_class == FMT_UNKNOWN, res_s2.instr_id == ID_NONE && res_s2.immediate == '0 && res_s2.dest_reg == '0, "unknown opcode left fields set")
	`RV32ID_ASSERT_NOW(a_r_no_imm, valid_s2 && res_s2.format_class == FMT_R, res_s2.immediate == '0, "register op carries an immediate")
	`RV32ID_ASSERT_NOW(a_lui_is_u, valid_s2 && res_s2.instr_id == ID_LUI, res_s2.format_class == FMT_U && res_s2.src_reg_a == '0, "lui decoded with the wrong format")

endmodule
